// File: design/ip3_pkg.sv
// Shared types and codes for the induced three-vertex path enumerator.
package ip3_pkg;

  localparam int unsigned CntW   = 7;
  localparam int unsigned VtxW   = 6;
  localparam int unsigned RowW   = 64;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned RegIdW = 2;

  localparam logic [CmdW-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CmdW-1:0] CMD_RESTART = 2'd1;
  localparam logic [CmdW-1:0] CMD_FETCH   = 2'd2;

  localparam logic [StatW-1:0] ST_ACK       = 2'd0;
  localparam logic [StatW-1:0] ST_FOUND     = 2'd1;
  localparam logic [StatW-1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [RegIdW-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [RegIdW-1:0] REG_NEAR_ON      = 2'd1;
  localparam logic [RegIdW-1:0] REG_NEAR_FIRST   = 2'd2;
  localparam logic [RegIdW-1:0] REG_NEAR_SECOND  = 2'd3;

  typedef struct packed {
    logic [CntW-1:0] vertex_count;
    logic            near_on;
    logic [VtxW-1:0] near_first;
    logic [VtxW-1:0] near_second;
  } cfg_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [VtxW-1:0]  end_low;
    logic [VtxW-1:0]  middle;
    logic [VtxW-1:0]  end_high;
  } res_t;

endpackage

// File: design/ip3_adj_mem.sv
// Adjacency row memory: one write port, one registered read port.
module ip3_adj_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IdxW-1:0]  waddr_i,
  input  logic [Depth-1:0] wdata_i,
  input  logic [IdxW-1:0]  raddr_i,
  output logic [Depth-1:0] rdata_o
);

  logic [Depth-1:0] mem_q [Depth];
  logic [Depth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ip3_zfind.sv
// First-set-bit search over the centre candidate vector.
module ip3_zfind #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic             clk_i,
  input  logic [Depth-1:0] vec_i,
  output logic             found_o,
  output logic [IdxW-1:0]  idx_o
);

  localparam int unsigned Groups = (Depth + 7) / 8;

  logic [Groups*8-1:0] pad;
  logic [Groups*8-1:0] pad_q;
  logic [Groups-1:0]   grp_q;
  logic [2:0]          sel;
  logic [2:0]          bsel;
  logic [7:0]          byte_w;
  logic [5:0]          pos;

  always_comb begin
    pad = '0;
    pad[Depth-1:0] = vec_i;
  end

  always_ff @(posedge clk_i) begin
    pad_q <= pad;
    for (int g = 0; g < Groups; g++) begin
      grp_q[g] <= |pad[g*8 +: 8];
    end
  end

  always_comb begin
    sel = '0;
    for (int g = Groups - 1; g >= 0; g--) begin
      if (grp_q[g]) sel = 3'(g);
    end
    byte_w = pad_q[sel*8 +: 8];
    bsel = '0;
    for (int b = 7; b >= 0; b--) begin
      if (byte_w[b]) bsel = 3'(b);
    end
    pos = {sel, bsel};
  end

  assign found_o = |grp_q;
  assign idx_o   = pos[IdxW-1:0];

endmodule

// File: design/ip3_scan.sv
// Command sequencer and path scan over the adjacency memory.
module ip3_scan
  import ip3_pkg::*;
#(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CmdW-1:0]  cmd_i,
  input  cfg_t             cfg_i,
  input  logic [Depth-1:0] rdata_i,
  output logic [IdxW-1:0]  raddr_o,
  output logic             idle_o,
  output logic             res_valid_o,
  input  logic             res_take_i,
  output res_t             res_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDX   = 6'b000010,
    S_YSCAN = 6'b000100,
    S_RDY   = 6'b001000,
    S_ZF    = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  x_q, x_d, y_q, y_d, zs_q, zs_d;
  logic [CntW-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d, cur_z_q, cur_z_d;
  logic             exh_q, exh_d;
  logic [Depth-1:0] rx_q, rx_d;
  res_t             res_q, res_d;

  logic [CntW-1:0]  n_live;
  logic [CntW-1:0]  x_next;
  logic [Depth-1:0] live_mask;
  logic [Depth-1:0] near_mask;
  logic [Depth-1:0] zvec;
  logic             has_u, has_v;
  logic             z_found;
  logic [IdxW-1:0]  z_idx;

  assign n_live = (cfg_i.vertex_count > CntW'(Depth)) ? CntW'(Depth) : cfg_i.vertex_count;
  assign x_next = x_q + 1'b1;
  assign has_u  = (x_q == {1'b0, cfg_i.near_first})  || (y_q == {1'b0, cfg_i.near_first});
  assign has_v  = (x_q == {1'b0, cfg_i.near_second}) || (y_q == {1'b0, cfg_i.near_second});

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      live_mask[j] = CntW'(j) < n_live;
      near_mask[j] = !cfg_i.near_on ||
                     ((has_u || CntW'(j) == {1'b0, cfg_i.near_first}) &&
                      (has_v || CntW'(j) == {1'b0, cfg_i.near_second}));
      zvec[j] = rdata_i[j] && rx_q[j] && (CntW'(j) >= zs_q) && near_mask[j];
    end
  end

  ip3_zfind #(
    .Depth(Depth),
    .IdxW (IdxW)
  ) u_zfind (
    .clk_i  (clk_i),
    .vec_i  (zvec),
    .found_o(z_found),
    .idx_o  (z_idx)
  );

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    zs_d    = zs_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    cur_z_d = cur_z_q;
    exh_d   = exh_q;
    rx_d    = rx_q;
    res_d   = res_q;
    raddr_o = x_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        raddr_o = cur_x_q[IdxW-1:0];
        if (start_i) begin
          res_d   = '0;
          state_d = S_EMIT;
          case (cmd_i)
            CMD_RESTART: begin
              cur_x_d = '0;
              cur_y_d = '0;
              cur_z_d = '0;
              exh_d   = 1'b0;
            end
            CMD_FETCH: begin
              if (exh_q) begin
                res_d.status = ST_EXHAUSTED;
              end else if (cur_x_q >= n_live) begin
                cur_x_d      = n_live;
                cur_y_d      = '0;
                cur_z_d      = '0;
                exh_d        = 1'b1;
                res_d.status = ST_EXHAUSTED;
              end else begin
                x_d     = cur_x_q;
                y_d     = cur_y_q;
                zs_d    = cur_z_q;
                state_d = S_RDX;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDX: begin
        rx_d    = rdata_i & live_mask;
        state_d = S_YSCAN;
      end
      S_YSCAN: begin
        if (y_q >= x_q) begin
          raddr_o = x_next[IdxW-1:0];
          x_d     = x_next;
          y_d     = '0;
          zs_d    = '0;
          if (x_next >= n_live) begin
            cur_x_d      = n_live;
            cur_y_d      = '0;
            cur_z_d      = '0;
            exh_d        = 1'b1;
            res_d        = '0;
            res_d.status = ST_EXHAUSTED;
            state_d      = S_EMIT;
          end else begin
            state_d = S_RDX;
          end
        end else if (!rx_q[y_q[IdxW-1:0]]) begin
          raddr_o = y_q[IdxW-1:0];
          state_d = S_RDY;
        end else begin
          y_d  = y_q + 1'b1;
          zs_d = '0;
        end
      end
      S_RDY: begin
        state_d = S_ZF;
      end
      S_ZF: begin
        if (z_found) begin
          cur_x_d        = x_q;
          cur_y_d        = y_q;
          cur_z_d        = CntW'(z_idx) + 1'b1;
          res_d.status   = ST_FOUND;
          res_d.end_low  = VtxW'(y_q);
          res_d.middle   = VtxW'(z_idx);
          res_d.end_high = VtxW'(x_q);
          state_d        = S_EMIT;
        end else begin
          y_d     = y_q + 1'b1;
          zs_d    = '0;
          state_d = S_YSCAN;
        end
      end
      S_EMIT: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      zs_q    <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      cur_z_q <= '0;
      exh_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
      zs_q    <= zs_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      cur_z_q <= cur_z_d;
      exh_q   <= exh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q  <= rx_d;
    res_q <= res_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

endmodule

// File: design/induced_p3_enumerator_unit.sv
// Top level of the induced three-vertex path enumerator.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_stall_o  command_i, vertex_i, row_bits_i
//  out      source     out_valid_o/out_stall_i status_o, end_low_o, middle_o, end_high_o
//  cfg      sink       cfg_we_i               cfg_idx_i, cfg_data_i
//
// Row write, restart: each word is accepted and its reply registered. Fetch: each x
// row is read from the adjacency memory and its y candidates scanned in turn; a
// neighbour y is skipped, a non-neighbour y has its row read and then the centre
// search run; the single memory read port sets the pace.
// Reset clears state, cursors and settings; adjacency rows are undefined until written.
// One word in flight; the output register lets the next word in while a result waits.
module induced_p3_enumerator_unit
  import ip3_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [VtxW-1:0]   vertex_i,
  input  logic [RowW-1:0]   row_bits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StatW-1:0]  status_o,
  output logic [VtxW-1:0]   end_low_o,
  output logic [VtxW-1:0]   middle_o,
  output logic [VtxW-1:0]   end_high_o,
  input  logic              cfg_we_i,
  input  logic [RegIdW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]   cfg_data_i
);

  localparam int unsigned Depth = (MAX_VERTICES < RowW) ? MAX_VERTICES : RowW;
  localparam int unsigned IdxW  = $clog2(Depth);

  cfg_t             cfg_q;
  res_t             eng_res;
  res_t             out_q;
  logic             out_valid_q;
  logic             eng_idle;
  logic             eng_res_valid;
  logic             res_take;
  logic             accept;
  logic             mem_we;
  logic [IdxW-1:0]  raddr;
  logic [Depth-1:0] rdata;

  assign accept   = in_valid_i && eng_idle;
  assign mem_we   = accept && (command_i == CMD_WRITE) &&
                    ({1'b0, vertex_i} < CntW'(Depth));
  assign res_take = eng_res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VERTEX_COUNT: cfg_q.vertex_count <= cfg_data_i;
        REG_NEAR_ON:      cfg_q.near_on      <= cfg_data_i[0];
        REG_NEAR_FIRST:   cfg_q.near_first   <= cfg_data_i[VtxW-1:0];
        REG_NEAR_SECOND:  cfg_q.near_second  <= cfg_data_i[VtxW-1:0];
        default: ;
      endcase
    end
  end

  ip3_adj_mem #(
    .Depth(Depth),
    .IdxW (IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(vertex_i[IdxW-1:0]),
    .wdata_i(row_bits_i[Depth-1:0]),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ip3_scan #(
    .Depth(Depth),
    .IdxW (IdxW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .cmd_i      (command_i),
    .cfg_i      (cfg_q),
    .rdata_i    (rdata),
    .raddr_o    (raddr),
    .idle_o     (eng_idle),
    .res_valid_o(eng_res_valid),
    .res_take_i (res_take),
    .res_o      (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) out_q <= eng_res;
  end

  assign in_stall_o  = !eng_idle;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign end_low_o   = out_q.end_low;
  assign middle_o    = out_q.middle;
  assign end_high_o  = out_q.end_high;

endmodule

// File: dv/induced_p3_enumerator_unit_tb.sv
// Testbench for the induced three-vertex path enumerator: random and directed words checked against a behavioural copy.
module induced_p3_enumerator_unit_tb;
  import ip3_pkg::*;

  localparam logic [CmdW-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned WordTarget = 1550;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [VtxW-1:0] vtx;
    logic [RowW-1:0] row;
  } word_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [CmdW-1:0]   command_i   = '0;
  logic [VtxW-1:0]   vertex_i    = '0;
  logic [RowW-1:0]   row_bits_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [StatW-1:0]  status_o;
  logic [VtxW-1:0]   end_low_o;
  logic [VtxW-1:0]   middle_o;
  logic [VtxW-1:0]   end_high_o;
  logic              cfg_we_i    = 1'b0;
  logic [RegIdW-1:0] cfg_idx_i   = '0;
  logic [CntW-1:0]   cfg_data_i  = '0;

  induced_p3_enumerator_unit #(
    .MAX_VERTICES(64)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .vertex_i   (vertex_i),
    .row_bits_i (row_bits_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .end_low_o  (end_low_o),
    .middle_o   (middle_o),
    .end_high_o (end_high_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // behavioural copy of the enumerator
  logic [RowW-1:0] adj_m [64];
  logic [CntW-1:0] m_count   = '0;
  logic            m_near_on = 1'b0;
  logic [VtxW-1:0] m_near_a  = '0;
  logic [VtxW-1:0] m_near_b  = '0;
  logic [CntW-1:0] m_cx      = '0;
  logic [CntW-1:0] m_cy      = '0;
  logic [CntW-1:0] m_cz      = '0;
  logic            m_done    = 1'b0;

  word_t pending_words [$];
  res_t  replies_due [$];
  word_t drv_word;
  res_t  mon_exp;
  int    queued_cnt   = 0;
  int    accepted_cnt = 0;
  int    err_cnt      = 0;
  logic  in_fire      = 1'b0;
  int    gap_left     = 0;
  int    burst_left   = 1;
  int    stall_mode   = 0;
  int    mode_left    = 0;
  int    tick         = 0;

  function automatic bit near_ok(int unsigned y, int unsigned z, int unsigned x);
    bit has_a, has_b;
    has_a = (y == m_near_a) || (z == m_near_a) || (x == m_near_a);
    has_b = (y == m_near_b) || (z == m_near_b) || (x == m_near_b);
    return !m_near_on || (has_a && has_b);
  endfunction

  task automatic compute_p3_reply(input word_t w);
    res_t r;
    int unsigned n, x, y, z, sx, sy, sz;
    logic [RowW-1:0] msk, rx, ys, zs;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (w.cmd)
      CMD_WRITE: adj_m[w.vtx] = w.row;
      CMD_RESTART: begin
        m_cx = '0;
        m_cy = '0;
        m_cz = '0;
        m_done = 1'b0;
      end
      CMD_FETCH: begin
        if (!m_done) begin
          n = (m_count > 64) ? 64 : m_count;
          msk = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
          sx = m_cx;
          sy = m_cy;
          sz = m_cz;
          for (x = sx; x < n && !hit; x++) begin
            rx = adj_m[x] & msk;
            ys = ~rx & msk & ~(64'd1 << x);
            for (y = (x == sx) ? sy : 0; y < x && !hit; y++) begin
              if (ys[y]) begin
                zs = adj_m[y] & rx;
                for (z = (x == sx && y == sy) ? sz : 0; z < n && !hit; z++) begin
                  if (zs[z] && near_ok(y, z, x)) begin
                    hit = 1'b1;
                    m_cx = CntW'(x);
                    m_cy = CntW'(y);
                    m_cz = CntW'(z + 1);
                    r.status = ST_FOUND;
                    r.end_low = VtxW'(y);
                    r.middle = VtxW'(z);
                    r.end_high = VtxW'(x);
                  end
                end
              end
            end
          end
          if (!hit) begin
            m_cx = CntW'(n);
            m_cy = '0;
            m_cz = '0;
            m_done = 1'b1;
          end
        end
        if (!hit) r.status = ST_EXHAUSTED;
      end
      default: ;
    endcase
    replies_due.push_back(r);
  endtask

  // input side: word taken at the rising edge, next one driven at the falling edge
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && in_stall_o === 1'b0;
    if (rst_ni && in_valid_i && in_stall_o === 1'b0) begin
      compute_p3_reply('{command_i, vertex_i, row_bits_i});
      accepted_cnt++;
    end
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drv_word = pending_words.pop_front();
        in_valid_i <= 1'b1;
        command_i <= drv_word.cmd;
        vertex_i <= drv_word.vtx;
        row_bits_i <= drv_word.row;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    tick++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 30);
      2: out_stall_i <= ($urandom_range(0, 99) < 75);
      default: out_stall_i <= (tick % 4 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (replies_due.size() == 0) begin
        $error("unexpected word: status %0d", status_o);
        err_cnt++;
      end else begin
        mon_exp = replies_due.pop_front();
        if (status_o !== mon_exp.status) begin
          $error("status: expected %0d, got %0d", mon_exp.status, status_o);
          err_cnt++;
        end
        if (end_low_o !== mon_exp.end_low) begin
          $error("end_low: expected %0d, got %0d", mon_exp.end_low, end_low_o);
          err_cnt++;
        end
        if (middle_o !== mon_exp.middle) begin
          $error("middle: expected %0d, got %0d", mon_exp.middle, middle_o);
          err_cnt++;
        end
        if (end_high_o !== mon_exp.end_high) begin
          $error("end_high: expected %0d, got %0d", mon_exp.end_high, end_high_o);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [RowW-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  task automatic push_word(input logic [CmdW-1:0] cmd, input logic [VtxW-1:0] vtx,
                           input logic [RowW-1:0] row);
    word_t w;
    w.cmd = cmd;
    w.vtx = vtx;
    w.row = row;
    pending_words.push_back(w);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (accepted_cnt != queued_cnt || replies_due.size() != 0);
  endtask

  task automatic set_reg(input logic [RegIdW-1:0] idx, input logic [CntW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_VERTEX_COUNT: m_count = data;
      REG_NEAR_ON: m_near_on = data[0];
      REG_NEAR_FIRST: m_near_a = data[VtxW-1:0];
      REG_NEAR_SECOND: m_near_b = data[VtxW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CntW-1:0] vc, input logic on,
                           input logic [VtxW-1:0] a, input logic [VtxW-1:0] b);
    wait_idle();
    set_reg(REG_VERTEX_COUNT, vc);
    set_reg(REG_NEAR_ON, CntW'(on));
    set_reg(REG_NEAR_FIRST, CntW'(a));
    set_reg(REG_NEAR_SECOND, CntW'(b));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // every row the scan can read is written before the first fetch
  task automatic load_rows(input int eff, input int dens);
    logic [RowW-1:0] g [64];
    int i, j;
    bit sym, b;
    sym = ($urandom_range(0, 99) < 85);
    for (i = 0; i < 64; i++) g[i] = rand_row();
    for (i = 0; i < eff; i++) begin
      g[i][i] = ($urandom_range(0, 99) < 15);
      for (j = i + 1; j < eff; j++) begin
        b = ($urandom_range(0, 99) < dens);
        g[i][j] = b;
        g[j][i] = sym ? b : ($urandom_range(0, 99) < dens);
      end
    end
    for (i = 0; i < eff; i++) push_word(CMD_WRITE, VtxW'(i), g[i]);
  endtask

  task automatic run_phase(input int vc_pick);
    logic [CntW-1:0] vc;
    logic [VtxW-1:0] na, nb;
    int eff, pick, words, k, dens;
    pick = $urandom_range(0, 99);
    if (vc_pick >= 0) vc = CntW'(vc_pick);
    else if (pick < 7) vc = 7'd64;
    else if (pick < 10) vc = CntW'($urandom_range(65, 127));
    else if (pick < 15) vc = CntW'($urandom_range(0, 2));
    else vc = CntW'($urandom_range(3, 12));
    eff = (vc > 64) ? 64 : vc;
    if (eff == 0 || $urandom_range(0, 3) == 0) na = VtxW'($urandom_range(0, 63));
    else na = VtxW'($urandom_range(0, eff - 1));
    if (eff == 0 || $urandom_range(0, 3) == 0) nb = VtxW'($urandom_range(0, 63));
    else nb = VtxW'($urandom_range(0, eff - 1));
    if ($urandom_range(0, 3) == 0) nb = na;
    case ($urandom_range(0, 5))
      0: dens = 0;
      1: dens = 30;
      4: dens = 70;
      5: dens = 100;
      default: dens = 50;
    endcase
    configure(vc, 1'($urandom_range(0, 1)), na, nb);
    load_rows(eff, dens);
    // without a restart the cursor carries over into the new settings
    if ($urandom_range(0, 3) != 0) push_word(CMD_RESTART, VtxW'($urandom), rand_row());
    words = (eff >= 64) ? $urandom_range(6, 14) : $urandom_range(25, 60);
    for (k = 0; k < words; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) push_word(CMD_FETCH, VtxW'($urandom), rand_row());
      else if (pick < 80) push_word(CMD_RESTART, VtxW'($urandom), rand_row());
      else if (pick < 90) push_word(CMD_WRITE, VtxW'($urandom), rand_row());
      else push_word(CMD_SPARE, VtxW'($urandom), rand_row());
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no vertices, so fetches report exhausted
    push_word(CMD_FETCH, '0, '0);
    push_word(CMD_FETCH, '1, '1);
    push_word(CMD_SPARE, '1, '1);
    push_word(CMD_RESTART, '0, '1);
    push_word(CMD_FETCH, '0, '0);
    push_word(CMD_WRITE, '1, '1);

    // four vertices, asymmetric rows, a self-loop and junk above the live bits
    configure(7'd4, 1'b0, 6'd0, 6'd0);
    push_word(CMD_WRITE, 6'd0, 64'hFFFF_FFFF_FFFF_FFF6);
    push_word(CMD_WRITE, 6'd1, 64'h8000_0000_0000_0005);
    push_word(CMD_WRITE, 6'd2, 64'h0000_0000_0000_000C);
    push_word(CMD_WRITE, 6'd3, 64'h0000_0000_0000_0002);
    repeat (4) push_word(CMD_FETCH, '0, '0);
    push_word(CMD_RESTART, '0, '0);
    push_word(CMD_FETCH, '0, '0);

    // equal near vertices, cursor kept, row rewritten mid-scan
    configure(7'd4, 1'b1, 6'd2, 6'd2);
    push_word(CMD_FETCH, '0, '0);
    push_word(CMD_WRITE, 6'd3, 64'h0000_0000_0000_0006);
    push_word(CMD_FETCH, '0, '0);
    push_word(CMD_RESTART, '0, '0);
    push_word(CMD_FETCH, '0, '0);
    push_word(CMD_FETCH, '0, '0);

    run_phase(64);
    run_phase(127);
    while (queued_cnt < WordTarget) run_phase(-1);

    wait_idle();
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: sim.f
design/ip3_pkg.sv
design/ip3_adj_mem.sv
design/ip3_zfind.sv
design/ip3_scan.sv
design/induced_p3_enumerator_unit.sv
dv/induced_p3_enumerator_unit_tb.sv
